### sv/sgm_pca_pkg.sv
// Shared types and constants for the SGM path cost aggregation block.
// Used by every module of the block; depends on nothing.
package sgm_pca_pkg;

    localparam int MAX_DISP   = 64;
    localparam int DISP_W     = $clog2(MAX_DISP);
    localparam int CNT_W      = $clog2(MAX_DISP + 1);
    localparam int COST_W     = 16;
    localparam int GRAY_W     = 8;
    localparam int MCOST_W    = 8;
    localparam int DIVISOR_W  = GRAY_W + 1;
    localparam int DIV_STEPS  = COST_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_AW     = DISP_W + 1;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [COST_W-1:0] EDGE_COST = 16'h7FFF;
    localparam logic [COST_W-1:0] MIN_INIT  = 16'hFFFF;

    localparam logic [COST_W-1:0] RST_PENALTY_SMALL   = 16'd10;
    localparam logic [COST_W-1:0] RST_PENALTY_LARGE   = 16'd150;
    localparam logic [CNT_W-1:0]  RST_DISPARITY_COUNT = CNT_W'(MAX_DISP);

    // Register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_PENALTY_SMALL   = 2'd0;
    localparam logic [1:0] REG_PENALTY_LARGE   = 2'd1;
    localparam logic [1:0] REG_DISPARITY_COUNT = 2'd2;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic                start;
        logic                first;
        logic                last;
        logic [DISP_W-1:0]   disp;
        logic [GRAY_W-1:0]   diff;
        logic [MCOST_W-1:0]  mcost;
        logic [COST_W-1:0]   sum_in;
    } t_item;

    typedef struct packed {
        logic                 start;
        logic [COST_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [COST_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_FETCH,
        BACK_MIN,
        BACK_COST
    } t_back_state;

endpackage

### sv/sgm_pca_front.sv
// Front end: accepts input transactions and tags each with its disparity,
// path and pixel flags and gray difference. Depends on sgm_pca_pkg.
module sgm_pca_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_path_start,
    input  logic [sgm_pca_pkg::GRAY_W-1:0]   i_gray,
    input  logic [sgm_pca_pkg::MCOST_W-1:0]  i_match_cost,
    input  logic [sgm_pca_pkg::COST_W-1:0]   i_sum_in,
    input  logic [sgm_pca_pkg::CNT_W-1:0]    i_disparity_count,
    input  logic                             i_full,
    output logic                             o_push,
    output sgm_pca_pkg::t_item               o_item
);

    logic [sgm_pca_pkg::DISP_W-1:0] r_pos, n_pos;
    logic                           r_first, n_first;
    logic [sgm_pca_pkg::GRAY_W-1:0] r_prev_gray, n_prev_gray;

    logic [sgm_pca_pkg::CNT_W-1:0]  w_cnt_eff;
    logic [sgm_pca_pkg::CNT_W-1:0]  w_next_pos;
    logic [sgm_pca_pkg::DISP_W-1:0] w_disp;
    logic                           w_first;
    logic                           w_last;

    always_comb begin
        if (i_disparity_count == '0) begin
            w_cnt_eff = sgm_pca_pkg::CNT_W'(1);
        end else if (i_disparity_count > sgm_pca_pkg::CNT_W'(sgm_pca_pkg::MAX_DISP)) begin
            w_cnt_eff = sgm_pca_pkg::CNT_W'(sgm_pca_pkg::MAX_DISP);
        end else begin
            w_cnt_eff = i_disparity_count;
        end
    end

    // A path start restarts the disparity count and the first-pixel phase.
    assign w_disp     = i_path_start ? '0 : r_pos;
    assign w_first    = i_path_start ? 1'b1 : r_first;
    assign w_next_pos = sgm_pca_pkg::CNT_W'(w_disp) + sgm_pca_pkg::CNT_W'(1);
    assign w_last     = (w_next_pos >= w_cnt_eff);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_item.start  = i_path_start;
        o_item.first  = w_first;
        o_item.last   = w_last;
        o_item.disp   = w_disp;
        o_item.diff   = (i_gray > r_prev_gray) ? (i_gray - r_prev_gray)
                                                : (r_prev_gray - i_gray);
        o_item.mcost  = i_match_cost;
        o_item.sum_in = i_sum_in;
    end

    always_comb begin
        n_pos       = r_pos;
        n_first     = r_first;
        n_prev_gray = r_prev_gray;
        if (o_push) begin
            if (w_last) begin
                n_pos       = '0;
                n_first     = 1'b0;
                n_prev_gray = i_gray;
            end else begin
                n_pos   = w_next_pos[sgm_pca_pkg::DISP_W-1:0];
                n_first = w_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first     <= 1'b1;
            r_prev_gray <= '0;
        end else begin
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_prev_gray <= n_prev_gray;
        end
    end

endmodule

### sv/sgm_pca_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on sgm_pca_pkg for the item type and depth.
module sgm_pca_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sgm_pca_pkg::t_item i_item,
    input  logic               i_pop,
    output sgm_pca_pkg::t_item o_head,
    output logic               o_full,
    output logic               o_empty
);

    sgm_pca_pkg::t_item r_mem [sgm_pca_pkg::FIFO_DEPTH];

    logic [sgm_pca_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [sgm_pca_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [sgm_pca_pkg::FIFO_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == sgm_pca_pkg::FIFO_CNT_W'(sgm_pca_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == sgm_pca_pkg::FIFO_PTR_W'(sgm_pca_pkg::FIFO_DEPTH - 1))
                       ? '0 : r_wr_ptr + sgm_pca_pkg::FIFO_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == sgm_pca_pkg::FIFO_PTR_W'(sgm_pca_pkg::FIFO_DEPTH - 1))
                       ? '0 : r_rd_ptr + sgm_pca_pkg::FIFO_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + sgm_pca_pkg::FIFO_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - sgm_pca_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### sv/sgm_pca_div.sv
// Restoring divider, one quotient bit per cycle, for the large-jump penalty.
// Depends on sgm_pca_pkg for widths and request/response types.
module sgm_pca_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sgm_pca_pkg::t_div_req i_req,
    output sgm_pca_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic [sgm_pca_pkg::STEP_W-1:0]      r_step;
    logic [sgm_pca_pkg::COST_W-1:0]      r_quo;
    logic [sgm_pca_pkg::GRAY_W-1:0]      r_rem;
    logic [sgm_pca_pkg::DIVISOR_W-1:0]   r_div;

    logic [sgm_pca_pkg::DIVISOR_W-1:0]   w_rem_sh;
    logic [sgm_pca_pkg::DIVISOR_W-1:0]   w_rem_sub;
    logic                                w_ge;

    // The remainder stays below the divisor, so it fits in the gray width.
    assign w_rem_sh  = {r_rem, r_quo[sgm_pca_pkg::COST_W-1]};
    assign w_ge      = (w_rem_sh >= r_div);
    assign w_rem_sub = w_rem_sh - r_div;

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + sgm_pca_pkg::STEP_W'(1);
            if (r_step == sgm_pca_pkg::STEP_W'(sgm_pca_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[sgm_pca_pkg::COST_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[sgm_pca_pkg::GRAY_W-1:0]
                          : w_rem_sh[sgm_pca_pkg::GRAY_W-1:0];
        end
    end

endmodule

### sv/sgm_pca_back.sv
// Back end: fetches neighbor path costs from the ping-pong cost memory,
// runs the divider, forms the path cost and holds the output register.
// Depends on sgm_pca_pkg and sgm_pca_div.
module sgm_pca_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sgm_pca_pkg::t_item              i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic [sgm_pca_pkg::COST_W-1:0]  i_penalty_small,
    input  logic [sgm_pca_pkg::COST_W-1:0]  i_penalty_large,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sgm_pca_pkg::COST_W-1:0]  o_path_cost,
    output logic [sgm_pca_pkg::COST_W-1:0]  o_sum_out,
    output logic                            o_pixel_done
);

    sgm_pca_pkg::t_back_state r_state, n_state;

    sgm_pca_pkg::t_item                r_item;
    logic [1:0]                        r_k;
    logic [sgm_pca_pkg::COST_W-1:0]    r_lo, r_mid, r_hi, r_m;
    logic [sgm_pca_pkg::COST_W-1:0]    r_prev_min, r_cur_min;
    logic                              r_bank;
    logic [sgm_pca_pkg::COST_W-1:0]    r_rd_data;
    logic                              r_out_valid;
    logic [sgm_pca_pkg::COST_W-1:0]    r_out_cost, r_out_sum;
    logic                              r_out_last;

    // Two banks: the current pixel writes one, the previous pixel is read from the other.
    logic [sgm_pca_pkg::COST_W-1:0]    r_mem [2 * sgm_pca_pkg::MAX_DISP];

    sgm_pca_pkg::t_div_req             w_div_req;
    sgm_pca_pkg::t_div_rsp             w_div_rsp;
    logic [sgm_pca_pkg::MEM_AW-1:0]    w_rd_addr;
    logic [sgm_pca_pkg::DISP_W-1:0]    w_rd_disp;
    logic                              w_fire;

    logic [sgm_pca_pkg::COST_W-1:0]    w_lo, w_hi, w_jump, w_l1, w_l3, w_l4;
    logic [sgm_pca_pkg::COST_W-1:0]    w_m12, w_m34, w_m;
    logic [sgm_pca_pkg::COST_W-1:0]    w_cost, w_sum, w_min_base, w_min_new;

    sgm_pca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sgm_pca_pkg::BACK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_head.first ? sgm_pca_pkg::BACK_COST : sgm_pca_pkg::BACK_FETCH;
                end
            end
            sgm_pca_pkg::BACK_FETCH: begin
                if (r_k == 2'd3 && !w_div_rsp.busy) begin
                    n_state = sgm_pca_pkg::BACK_MIN;
                end
            end
            sgm_pca_pkg::BACK_MIN: begin
                n_state = sgm_pca_pkg::BACK_COST;
            end
            sgm_pca_pkg::BACK_COST: begin
                if (w_fire) begin
                    n_state = sgm_pca_pkg::BACK_IDLE;
                end
            end
            default: begin
                n_state = sgm_pca_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop              = 1'b0;
        w_fire             = 1'b0;
        w_rd_disp          = r_item.disp + sgm_pca_pkg::DISP_W'(1);
        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_penalty_large;
        w_div_req.divisor  = sgm_pca_pkg::DIVISOR_W'(i_head.diff)
                             + sgm_pca_pkg::DIVISOR_W'(1);
        case (r_state)
            sgm_pca_pkg::BACK_IDLE: begin
                o_pop           = !i_empty;
                w_div_req.start = !i_empty && !i_head.first;
            end
            sgm_pca_pkg::BACK_FETCH: begin
                case (r_k)
                    2'd0:    w_rd_disp = r_item.disp - sgm_pca_pkg::DISP_W'(1);
                    2'd1:    w_rd_disp = r_item.disp;
                    default: w_rd_disp = r_item.disp + sgm_pca_pkg::DISP_W'(1);
                endcase
            end
            sgm_pca_pkg::BACK_COST: begin
                w_fire = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign w_rd_addr = {~r_bank, w_rd_disp};

    // Neighbors outside the disparity range read as the edge cost.
    assign w_lo   = (r_item.disp == '0) ? sgm_pca_pkg::EDGE_COST : r_lo;
    assign w_hi   = r_item.last ? sgm_pca_pkg::EDGE_COST : r_hi;
    assign w_jump = (w_div_rsp.quotient > i_penalty_small) ? w_div_rsp.quotient
                                                           : i_penalty_small;
    assign w_l1   = w_lo + i_penalty_small;
    assign w_l3   = w_hi + i_penalty_small;
    assign w_l4   = r_prev_min + w_jump;
    assign w_m12  = (w_l1 < r_mid) ? w_l1 : r_mid;
    assign w_m34  = (w_l3 < w_l4) ? w_l3 : w_l4;
    assign w_m    = (w_m12 < w_m34) ? w_m12 : w_m34;

    assign w_cost = r_item.first ? sgm_pca_pkg::COST_W'(r_item.mcost)
                  : sgm_pca_pkg::COST_W'(r_item.mcost) + r_m - r_prev_min;
    assign w_sum  = r_item.first ? r_item.sum_in : r_item.sum_in + w_cost;
    assign w_min_base = r_item.start ? sgm_pca_pkg::MIN_INIT : r_cur_min;
    assign w_min_new  = (w_cost < w_min_base) ? w_cost : w_min_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgm_pca_pkg::BACK_IDLE;
            r_k         <= '0;
            r_prev_min  <= '0;
            r_cur_min   <= sgm_pca_pkg::MIN_INIT;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= '0;
            end else if (r_state == sgm_pca_pkg::BACK_FETCH && r_k != 2'd3) begin
                r_k <= r_k + 2'd1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                if (r_item.last) begin
                    r_prev_min <= w_min_new;
                    r_cur_min  <= sgm_pca_pkg::MIN_INIT;
                    r_bank     <= ~r_bank;
                end else begin
                    r_cur_min  <= w_min_new;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (r_state == sgm_pca_pkg::BACK_FETCH) begin
            case (r_k)
                2'd1:    r_lo  <= r_rd_data;
                2'd2:    r_mid <= r_rd_data;
                2'd3:    r_hi  <= r_rd_data;
                default: begin
                end
            endcase
        end
        if (r_state == sgm_pca_pkg::BACK_MIN) begin
            r_m <= w_m;
        end
        if (w_fire) begin
            r_out_cost <= w_cost;
            r_out_sum  <= w_sum;
            r_out_last <= r_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (w_fire) begin
            r_mem[{r_bank, r_item.disp}] <= w_cost;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_path_cost  = r_out_cost;
    assign o_sum_out    = r_out_sum;
    assign o_pixel_done = r_out_last;

endmodule

### sv/sgm_path_cost_aggregation.sv
// SGM path cost aggregation along one scan path, one disparity per transaction.
// Input transactions carry path_start, gray, match_cost and sum_in; each yields
// one output transaction with path_cost, sum_out and pixel_done.
// Both channels use valid/ready; a transaction moves when both are high.
// Penalties and the disparity count sit in APB registers at 0x0, 0x4, 0x8;
// write them only while the block is idle.
// An item on a path's first pixel passes from the queue through the back end's
// idle and cost states into the output register; later items also pass the fetch
// and min states, where they wait on the bit-serial divider for the large-jump
// penalty. The back end takes no new item until the last result is registered.
// A two-entry queue lets the input side keep accepting while the back end works.
// Reset (synchronous, active low) loads the default register values, empties
// the queue and starts a new path; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the back
// end waits, and input ready drops once the queue fills.
// Depends on sgm_pca_pkg, sgm_pca_front, sgm_pca_fifo and sgm_pca_back.
module sgm_path_cost_aggregation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sgm_pca_pkg::APB_AW-1:0]   paddr,
    input  logic [sgm_pca_pkg::APB_DW-1:0]   pwdata,
    output logic [sgm_pca_pkg::APB_DW-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_path_start,
    input  logic [sgm_pca_pkg::GRAY_W-1:0]   i_gray,
    input  logic [sgm_pca_pkg::MCOST_W-1:0]  i_match_cost,
    input  logic [sgm_pca_pkg::COST_W-1:0]   i_sum_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sgm_pca_pkg::COST_W-1:0]   o_path_cost,
    output logic [sgm_pca_pkg::COST_W-1:0]   o_sum_out,
    output logic                             o_pixel_done
);

    logic [sgm_pca_pkg::COST_W-1:0] r_penalty_small;
    logic [sgm_pca_pkg::COST_W-1:0] r_penalty_large;
    logic [sgm_pca_pkg::CNT_W-1:0]  r_disparity_count;

    logic                w_wr;
    logic [1:0]          w_reg_idx;
    logic                w_push, w_pop, w_full, w_empty;
    sgm_pca_pkg::t_item  w_item, w_head;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty_small   <= sgm_pca_pkg::RST_PENALTY_SMALL;
            r_penalty_large   <= sgm_pca_pkg::RST_PENALTY_LARGE;
            r_disparity_count <= sgm_pca_pkg::RST_DISPARITY_COUNT;
        end else if (w_wr) begin
            case (w_reg_idx)
                sgm_pca_pkg::REG_PENALTY_SMALL:
                    r_penalty_small <= pwdata[sgm_pca_pkg::COST_W-1:0];
                sgm_pca_pkg::REG_PENALTY_LARGE:
                    r_penalty_large <= pwdata[sgm_pca_pkg::COST_W-1:0];
                sgm_pca_pkg::REG_DISPARITY_COUNT:
                    r_disparity_count <= pwdata[sgm_pca_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            sgm_pca_pkg::REG_PENALTY_SMALL:
                prdata = sgm_pca_pkg::APB_DW'(r_penalty_small);
            sgm_pca_pkg::REG_PENALTY_LARGE:
                prdata = sgm_pca_pkg::APB_DW'(r_penalty_large);
            sgm_pca_pkg::REG_DISPARITY_COUNT:
                prdata = sgm_pca_pkg::APB_DW'(r_disparity_count);
            default:
                prdata = '0;
        endcase
    end

    sgm_pca_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_path_start      (i_path_start),
        .i_gray            (i_gray),
        .i_match_cost      (i_match_cost),
        .i_sum_in          (i_sum_in),
        .i_disparity_count (r_disparity_count),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_item            (w_item)
    );

    sgm_pca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sgm_pca_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_penalty_small (r_penalty_small),
        .i_penalty_large (r_penalty_large),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_path_cost     (o_path_cost),
        .o_sum_out       (o_sum_out),
        .o_pixel_done    (o_pixel_done)
    );

`ifndef SYNTHESIS
    // The back end never takes an item from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("item taken from an empty queue");

    // Input ready can only drop after a transaction has been queued.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(w_push))
        else $error("input ready dropped without a queued transaction");

    // A freshly loaded result follows an item taken from the queue earlier.
    a_out_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid ##1 o_out_valid) |-> !$past(w_pop))
        else $error("result loaded in the same cycle an item was taken");
`endif

endmodule

### sim/tb_top.sv
// Testbench for sgm_path_cost_aggregation: directed and random scan paths with a
// cycle-free predictor of the path costs, checked result by result.
// Depends on sgm_pca_pkg and the block's RTL only.
module tb_top;

    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 40;
    localparam int DRAIN_GUARD    = 50_000;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int PHASE_ITEMS    = 125;
    localparam int MAX_PRINTED    = 40;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [sgm_pca_pkg::COST_W-1:0] path_cost;
        logic [sgm_pca_pkg::COST_W-1:0] sum_out;
        logic                           pixel_done;
    } t_cost_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [sgm_pca_pkg::APB_AW-1:0]   paddr;
    logic [sgm_pca_pkg::APB_DW-1:0]   pwdata;
    logic [sgm_pca_pkg::APB_DW-1:0]   prdata;
    logic                             pready;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_path_start;
    logic [sgm_pca_pkg::GRAY_W-1:0]   i_gray;
    logic [sgm_pca_pkg::MCOST_W-1:0]  i_match_cost;
    logic [sgm_pca_pkg::COST_W-1:0]   i_sum_in;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [sgm_pca_pkg::COST_W-1:0]   o_path_cost;
    logic [sgm_pca_pkg::COST_W-1:0]   o_sum_out;
    logic                             o_pixel_done;

    // Predictor state and its copy of the registers.
    logic [sgm_pca_pkg::COST_W-1:0]   prev_path_costs [sgm_pca_pkg::MAX_DISP];
    logic [sgm_pca_pkg::COST_W-1:0]   cur_path_costs  [sgm_pca_pkg::MAX_DISP];
    logic [sgm_pca_pkg::COST_W-1:0]   prev_min_cost;
    logic [sgm_pca_pkg::COST_W-1:0]   cur_min_cost;
    logic [sgm_pca_pkg::GRAY_W-1:0]   prev_gray_level;
    int unsigned                      disp_index;
    logic                             on_first_pixel;
    int unsigned                      prev_pixel_width;
    logic [sgm_pca_pkg::COST_W-1:0]   cfg_p1;
    logic [sgm_pca_pkg::COST_W-1:0]   cfg_p2;
    logic [sgm_pca_pkg::CNT_W-1:0]    cfg_disp_count;

    t_cost_result                     pending_costs [$];
    t_idle_mode                       idle_mode = IDLE_NONE;
    int unsigned                      path_pixels_left = 0;
    logic [sgm_pca_pkg::GRAY_W-1:0]   pixel_gray = '0;

    int unsigned         items_sent = 0;
    int unsigned         results_checked = 0;
    int unsigned         pixels_checked = 0;
    int unsigned         settings_applied = 0;
    int unsigned         mismatches = 0;

    sgm_path_cost_aggregation u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_path_start (i_path_start),
        .i_gray       (i_gray),
        .i_match_cost (i_match_cost),
        .i_sum_in     (i_sum_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_path_cost  (o_path_cost),
        .o_sum_out    (o_sum_out),
        .o_pixel_done (o_pixel_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("Timeout after %0d cycles with %0d results still expected",
                 TIMEOUT_CYCLES, pending_costs.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned sender_gap_pct();
        case (idle_mode)
            IDLE_SENDER: return 60;
            IDLE_BOTH:   return 25;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 60;
            IDLE_BOTH:     return 25;
            default:       return 0;
        endcase
    endfunction

    // A count of zero behaves as one, anything above the maximum as the maximum.
    function automatic int unsigned active_disparities();
        if (cfg_disp_count == 0) return 1;
        if (cfg_disp_count > sgm_pca_pkg::MAX_DISP) return sgm_pca_pkg::MAX_DISP;
        return 32'(cfg_disp_count);
    endfunction

    function automatic int unsigned pick_value(input int unsigned max_value);
        case ($urandom_range(7))
            0:       return 0;
            1:       return max_value;
            default: return $urandom_range(max_value);
        endcase
    endfunction

    task automatic reset_predictor();
        cfg_p1           = sgm_pca_pkg::RST_PENALTY_SMALL;
        cfg_p2           = sgm_pca_pkg::RST_PENALTY_LARGE;
        cfg_disp_count   = sgm_pca_pkg::RST_DISPARITY_COUNT;
        prev_min_cost    = '0;
        cur_min_cost     = sgm_pca_pkg::MIN_INIT;
        prev_gray_level  = '0;
        disp_index       = 0;
        on_first_pixel   = 1'b1;
        prev_pixel_width = 0;
        foreach (prev_path_costs[i]) begin
            prev_path_costs[i] = '0;
            cur_path_costs[i]  = '0;
        end
    endtask

    // Advances the path state by one disparity and returns what the block must output.
    function automatic t_cost_result aggregate_cost(input logic start,
            input logic [sgm_pca_pkg::GRAY_W-1:0] gray,
            input logic [sgm_pca_pkg::MCOST_W-1:0] mcost,
            input logic [sgm_pca_pkg::COST_W-1:0] sum_in);
        t_cost_result                   res;
        int unsigned                    d;
        int unsigned                    count;
        logic                           last;
        logic [sgm_pca_pkg::GRAY_W-1:0] gray_diff;
        logic [sgm_pca_pkg::COST_W-1:0] lower, upper, jump, penalty;
        logic [sgm_pca_pkg::COST_W-1:0] step_down, stay, step_up, jump_cand, best;
        count = active_disparities();
        if (start) begin
            disp_index     = 0;
            on_first_pixel = 1'b1;
            cur_min_cost   = sgm_pca_pkg::MIN_INIT;
        end
        d    = (disp_index >= sgm_pca_pkg::MAX_DISP) ? sgm_pca_pkg::MAX_DISP - 1
                                                     : disp_index;
        last = (d + 1 >= count);
        if (on_first_pixel) begin
            res.path_cost = sgm_pca_pkg::COST_W'(mcost);
            res.sum_out   = sum_in;
        end else begin
            lower = sgm_pca_pkg::EDGE_COST;
            upper = sgm_pca_pkg::EDGE_COST;
            if (d != 0) lower = prev_path_costs[d-1];
            if (!last) upper = prev_path_costs[d+1];
            gray_diff = (gray > prev_gray_level) ? gray - prev_gray_level
                                                 : prev_gray_level - gray;
            jump      = cfg_p2 / ({1'b0, gray_diff} + 9'd1);
            penalty   = (jump > cfg_p1) ? jump : cfg_p1;
            step_down = lower + cfg_p1;
            stay      = prev_path_costs[d];
            step_up   = upper + cfg_p1;
            jump_cand = prev_min_cost + penalty;
            best      = step_down;
            if (stay < best) best = stay;
            if (step_up < best) best = step_up;
            if (jump_cand < best) best = jump_cand;
            res.path_cost = mcost + best - prev_min_cost;
            res.sum_out   = sum_in + res.path_cost;
        end
        res.pixel_done    = last;
        cur_path_costs[d] = res.path_cost;
        if (res.path_cost < cur_min_cost) cur_min_cost = res.path_cost;
        if (last) begin
            prev_path_costs  = cur_path_costs;
            prev_min_cost    = cur_min_cost;
            prev_gray_level  = gray;
            cur_min_cost     = sgm_pca_pkg::MIN_INIT;
            on_first_pixel   = 1'b0;
            disp_index       = 0;
            prev_pixel_width = d + 1;
        end else begin
            disp_index = d + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic send_item(input logic start,
                             input logic [sgm_pca_pkg::GRAY_W-1:0] gray,
                             input logic [sgm_pca_pkg::MCOST_W-1:0] mcost,
                             input logic [sgm_pca_pkg::COST_W-1:0] sum_in);
        // A pixel wider than the last finished one would read cost entries that
        // were never written, so such a pixel must open a new path.
        if (!on_first_pixel && active_disparities() > prev_pixel_width) start = 1'b1;
        while ($urandom_range(99) < sender_gap_pct()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_path_start <= start;
        i_gray       <= gray;
        i_match_cost <= mcost;
        i_sum_in     <= sum_in;
        do @(posedge i_clk); while (!o_in_ready);
        pending_costs.push_back(aggregate_cost(start, gray, mcost, sum_in));
        items_sent++;
    endtask

    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_costs.size() != 0 && waited < DRAIN_GUARD) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index,
                             input logic [sgm_pca_pkg::APB_DW-1:0] value);
        logic [sgm_pca_pkg::APB_DW-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            sgm_pca_pkg::REG_PENALTY_SMALL: cfg_p1 = value[sgm_pca_pkg::COST_W-1:0];
            sgm_pca_pkg::REG_PENALTY_LARGE: cfg_p2 = value[sgm_pca_pkg::COST_W-1:0];
            default: cfg_disp_count = value[sgm_pca_pkg::CNT_W-1:0];
        endcase
        stored = (index == sgm_pca_pkg::REG_DISPARITY_COUNT)
                 ? sgm_pca_pkg::APB_DW'(value[sgm_pca_pkg::CNT_W-1:0])
                 : sgm_pca_pkg::APB_DW'(value[sgm_pca_pkg::COST_W-1:0]);
        // Read the register straight back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored)
            report_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h",
                                      index, prdata, stored));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [sgm_pca_pkg::COST_W-1:0] p1,
                                  input logic [sgm_pca_pkg::COST_W-1:0] p2,
                                  input logic [sgm_pca_pkg::CNT_W-1:0] count);
        wait_drained();
        write_reg(sgm_pca_pkg::REG_PENALTY_SMALL, sgm_pca_pkg::APB_DW'(p1));
        write_reg(sgm_pca_pkg::REG_PENALTY_LARGE, sgm_pca_pkg::APB_DW'(p2));
        write_reg(sgm_pca_pkg::REG_DISPARITY_COUNT, sgm_pca_pkg::APB_DW'(count));
        settings_applied++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    always @(posedge i_clk) begin : check_results
        t_cost_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_costs.size() == 0) begin
                report_mismatch($sformatf("unexpected result cost=%0d sum=%0d done=%0b",
                                          o_path_cost, o_sum_out, o_pixel_done));
            end else begin
                want = pending_costs.pop_front();
                if (o_path_cost !== want.path_cost)
                    report_mismatch($sformatf("result %0d path_cost %0d, expected %0d",
                                              results_checked, o_path_cost, want.path_cost));
                if (o_sum_out !== want.sum_out)
                    report_mismatch($sformatf("result %0d sum_out %0d, expected %0d",
                                              results_checked, o_sum_out, want.sum_out));
                if (o_pixel_done !== want.pixel_done)
                    report_mismatch($sformatf("result %0d pixel_done %0b, expected %0b",
                                              results_checked, o_pixel_done, want.pixel_done));
                if (want.pixel_done) pixels_checked++;
                results_checked++;
            end
        end
    end

    // Field extremes with both penalties at full scale, so every penalized candidate wraps unless its base is zero.
    task automatic test_first_pixel_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, sgm_pca_pkg::CNT_W'(3));
        send_item(1'b1, 8'd0,   8'd0,   16'h0000);
        send_item(1'b0, 8'd0,   8'd255, 16'hFFFF);
        send_item(1'b0, 8'd0,   8'd128, 16'h1234);
        send_item(1'b0, 8'd255, 8'd255, 16'hFFFF);
        send_item(1'b0, 8'd255, 8'd0,   16'h0000);
        send_item(1'b0, 8'd255, 8'd1,   16'h8000);
        send_item(1'b0, 8'd255, 8'd200, 16'h00FF);
        send_item(1'b0, 8'd255, 8'd37,  16'hFF00);
        send_item(1'b0, 8'd255, 8'd255, 16'hFFFF);
    endtask

    // A zero count acts as a single disparity, so both neighbors are off the edge.
    task automatic test_count_extremes();
        apply_settings(16'd0, 16'd0, sgm_pca_pkg::CNT_W'(0));
        send_item(1'b1, 8'd9,   8'd200, 16'd100);
        send_item(1'b0, 8'd200, 8'd0,   16'hFFFF);
        send_item(1'b0, 8'd0,   8'd255, 16'd12345);
    endtask

    // Lowering the count mid-pixel ends the pixel; a path start mid-pixel drops it.
    task automatic test_mid_pixel_changes();
        apply_settings(16'd7, 16'd200, sgm_pca_pkg::CNT_W'(4));
        send_item(1'b1, 8'd50, 8'd12, 16'd1000);
        send_item(1'b0, 8'd50, 8'd3,  16'd2000);
        send_item(1'b0, 8'd50, 8'd90, 16'd3000);
        send_item(1'b0, 8'd50, 8'd41, 16'd4000);
        send_item(1'b0, 8'd60, 8'd5,  16'd10);
        send_item(1'b0, 8'd60, 8'd77, 16'd20);
        apply_settings(16'd7, 16'd200, sgm_pca_pkg::CNT_W'(2));
        send_item(1'b0, 8'd60,  8'd8,  16'd30);
        send_item(1'b0, 8'd100, 8'd60, 16'd40);
        send_item(1'b0, 8'd100, 8'd2,  16'd50);
        send_item(1'b0, 8'd90,  8'd33, 16'd60);
        send_item(1'b1, 8'd90,  8'd44, 16'd70);
        send_item(1'b0, 8'd90,  8'd55, 16'd80);
    endtask

    task automatic run_random_phase(input logic [sgm_pca_pkg::COST_W-1:0] p1,
                                    input logic [sgm_pca_pkg::COST_W-1:0] p2,
                                    input logic [sgm_pca_pkg::CNT_W-1:0] count,
                                    input t_idle_mode mode);
        logic start;
        int   g;
        apply_settings(p1, p2, count);
        idle_mode = mode;
        repeat (PHASE_ITEMS) begin
            start = 1'b0;
            if (disp_index == 0) begin
                if (path_pixels_left == 0) begin
                    start            = 1'b1;
                    path_pixels_left = $urandom_range(8, 1);
                end
                path_pixels_left--;
                // Mostly smooth gray along the path, with some hard edges.
                case ($urandom_range(7))
                    0, 1: g = pixel_gray;
                    2, 3: g = int'(pixel_gray) + int'($urandom_range(6)) - 3;
                    4:    g = 0;
                    5:    g = 255;
                    default: g = $urandom_range(255);
                endcase
                pixel_gray = (g < 0) ? 8'd0 : (g > 255) ? 8'd255
                                                        : sgm_pca_pkg::GRAY_W'(g);
            end else if ($urandom_range(39) == 0) begin
                start            = 1'b1;
                path_pixels_left = $urandom_range(7);
            end else if ($urandom_range(29) == 0) begin
                pixel_gray = sgm_pca_pkg::GRAY_W'($urandom_range(255));
            end
            send_item(start, pixel_gray, sgm_pca_pkg::MCOST_W'(pick_value(255)),
                      sgm_pca_pkg::COST_W'(pick_value(65535)));
        end
        idle_mode = IDLE_NONE;
    endtask

    task automatic test_random_paths();
        run_random_phase(16'd10, 16'd150, sgm_pca_pkg::CNT_W'(8), IDLE_NONE);
        run_random_phase(16'd0, 16'd0, sgm_pca_pkg::CNT_W'(1), IDLE_SENDER);
        run_random_phase(16'hFFFF, 16'hFFFF, sgm_pca_pkg::CNT_W'(64), IDLE_RECEIVER);
        run_random_phase(sgm_pca_pkg::COST_W'($urandom_range(65535)),
                         sgm_pca_pkg::COST_W'($urandom_range(65535)),
                         sgm_pca_pkg::CNT_W'($urandom_range(64, 1)), IDLE_BOTH);
        run_random_phase(sgm_pca_pkg::COST_W'($urandom_range(65535)), 16'hFFFF,
                         sgm_pca_pkg::CNT_W'(0), IDLE_NONE);
        run_random_phase(16'd0, sgm_pca_pkg::COST_W'($urandom_range(65535)),
                         sgm_pca_pkg::CNT_W'(127), IDLE_SENDER);
        run_random_phase(sgm_pca_pkg::COST_W'($urandom_range(300)),
                         sgm_pca_pkg::COST_W'($urandom_range(4000)),
                         sgm_pca_pkg::CNT_W'(100), IDLE_BOTH);
        run_random_phase(sgm_pca_pkg::COST_W'($urandom_range(50)),
                         sgm_pca_pkg::COST_W'($urandom_range(2000)),
                         sgm_pca_pkg::CNT_W'($urandom_range(16, 2)), IDLE_RECEIVER);
    endtask

    task automatic finish_run();
        wait_drained();
        if (pending_costs.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_costs.size()));
        $display("Covered %0d input transactions, %0d results checked, %0d pixels finished",
                 items_sent, results_checked, pixels_checked);
        $display("Used %0d register settings from zero to full-scale penalties, %0d mismatches",
                 settings_applied, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_in_valid   <= 1'b0;
        i_path_start <= 1'b0;
        i_gray       <= '0;
        i_match_cost <= '0;
        i_sum_in     <= '0;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_pixel_extremes();
        test_count_extremes();
        test_mid_pixel_changes();
        test_random_paths();
        finish_run();
    end

endmodule

### sgm_path_cost_aggregation.f
sv/sgm_pca_pkg.sv
sv/sgm_pca_front.sv
sv/sgm_pca_fifo.sv
sv/sgm_pca_div.sv
sv/sgm_pca_back.sv
sv/sgm_path_cost_aggregation.sv
sim/tb_top.sv
